FILE: hdl/spa_pkg.sv
// Shared types and constants of the sparse polynomial adder.
// Used by the front end, the command queue and the merge back end.
// No dependencies.
`default_nettype none

package spa_pkg;

	// Action codes as they arrive on the input channel.
	localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
	localparam logic [1:0] ACT_MERGE       = 2'd2;

	// Command queue between the front end and the back end.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	localparam logic signed [31:0] COEFF_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] COEFF_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		CMD_LOAD_FIRST,
		CMD_LOAD_SECOND,
		CMD_MERGE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic signed [31:0] coeff;
		logic [15:0]        power;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] coeff;
		logic [15:0]        power;
	} term_t;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} back_state_t;

endpackage

`default_nettype wire

FILE: hdl/spa_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on spa_pkg for the command type and the queue depth.
`default_nettype none

module spa_cmd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  spa_pkg::cmd_t      push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output spa_pkg::cmd_t      head_cmd
);
	import spa_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/spa_front.sv
// Front end: takes items from the input channel, decodes the action and
// pushes commands into the queue. Depends on spa_pkg.
`default_nettype none

module spa_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         action,
	input  wire logic signed [31:0] coeff,
	input  wire logic [15:0]        power,
	output logic                    push,
	output spa_pkg::cmd_t           push_cmd,
	input  wire logic               q_full
);
	import spa_pkg::*;

	logic      valid_s1;
	logic      keep_s1;
	cmd_t      cmd_s1;
	logic      keep_d;
	cmd_kind_t kind_d;

	// Unused action codes are accepted and discarded without reaching the queue.
	always_comb begin
		keep_d = 1'b1;
		kind_d = CMD_MERGE;
		unique case (action)
			ACT_LOAD_FIRST:  kind_d = CMD_LOAD_FIRST;
			ACT_LOAD_SECOND: kind_d = CMD_LOAD_SECOND;
			ACT_MERGE:       kind_d = CMD_MERGE;
			default:         keep_d = 1'b0;
		endcase
	end

	assign in_stall = valid_s1 && keep_s1 && q_full;
	assign push     = valid_s1 && keep_s1 && !q_full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			keep_s1  <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
			keep_s1  <= keep_d;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1.kind  <= kind_d;
			cmd_s1.coeff <= coeff;
			cmd_s1.power <= power;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/spa_back.sv
// Back end: holds the two term stores, runs the sorted merge and drives the
// output register. Depends on spa_pkg.
`default_nettype none

module spa_back #(
	parameter int unsigned TERM_DEPTH = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         head_valid,
	input  spa_pkg::cmd_t     head_cmd,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic signed [31:0] sum_coeff,
	output logic [15:0]       sum_power,
	output logic              last,
	output logic              empty_res,
	output logic              saturated,
	output logic              dropped
);
	import spa_pkg::*;

	localparam int unsigned CW = $clog2(TERM_DEPTH + 1);
	localparam int unsigned AW = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(TERM_DEPTH);

	term_t       mem_first  [2**AW];
	term_t       mem_second [2**AW];
	term_t       rd_first_q;
	term_t       rd_second_q;
	term_t       wr_term;

	back_state_t state_q, state_d;
	logic [CW-1:0] cnt_first_q, cnt_second_q;
	logic [CW-1:0] idx_first_q, idx_second_q;
	logic [CW-1:0] idx_first_inc, idx_second_inc;
	logic [CW-1:0] idx_first_d, idx_second_d;
	logic          overflow_q;

	logic slot_free, emit, clear, advance, done;
	logic wr_first, wr_second, drop_load;
	logic has_first, has_second, take_first, take_second;
	logic step_first, step_second;
	logic signed [32:0] wide_sum;
	logic signed [31:0] res_coeff;
	logic [15:0]        res_power;
	logic               res_last, res_empty, res_sat;

	logic               out_valid_q;
	logic signed [31:0] sum_coeff_q;
	logic [15:0]        sum_power_q;
	logic               last_q, empty_res_q, saturated_q, dropped_q;

	assign slot_free = !out_valid_q || !out_stall;

	// Merge decision on the registered heads of both stores.
	assign has_first   = idx_first_q < cnt_first_q;
	assign has_second  = idx_second_q < cnt_second_q;
	assign take_first  = !has_second || (has_first && rd_first_q.power < rd_second_q.power);
	assign take_second = !take_first &&
		(!has_first || rd_second_q.power < rd_first_q.power);
	assign step_first  = advance && !take_second;
	assign step_second = advance && !take_first;
	assign wide_sum    = {rd_first_q.coeff[31], rd_first_q.coeff} +
		{rd_second_q.coeff[31], rd_second_q.coeff};

	assign idx_first_inc  = idx_first_q + CW'(step_first);
	assign idx_second_inc = idx_second_q + CW'(step_second);
	assign done = advance && (idx_first_inc >= cnt_first_q) &&
		(idx_second_inc >= cnt_second_q);
	assign idx_first_d  = done ? '0 : idx_first_inc;
	assign idx_second_d = done ? '0 : idx_second_inc;

	assign wr_term.coeff = head_cmd.coeff;
	assign wr_term.power = head_cmd.power;

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		emit      = 1'b0;
		clear     = 1'b0;
		advance   = 1'b0;
		wr_first  = 1'b0;
		wr_second = 1'b0;
		drop_load = 1'b0;
		res_coeff = '0;
		res_power = '0;
		res_last  = 1'b0;
		res_empty = 1'b0;
		res_sat   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					unique case (head_cmd.kind)
						CMD_LOAD_FIRST: begin
							pop       = 1'b1;
							wr_first  = cnt_first_q < DEPTH_C;
							drop_load = !(cnt_first_q < DEPTH_C);
						end
						CMD_LOAD_SECOND: begin
							pop       = 1'b1;
							wr_second = cnt_second_q < DEPTH_C;
							drop_load = !(cnt_second_q < DEPTH_C);
						end
						CMD_MERGE: begin
							if (slot_free) begin
								pop = 1'b1;
								if (cnt_first_q == '0 && cnt_second_q == '0) begin
									emit      = 1'b1;
									clear     = 1'b1;
									res_last  = 1'b1;
									res_empty = 1'b1;
								end else begin
									state_d = ST_MERGE;
								end
							end
						end
						default: pop = 1'b1;
					endcase
				end
			end
			ST_MERGE: begin
				if (slot_free) begin
					advance  = 1'b1;
					emit     = 1'b1;
					res_last = done;
					if (take_first) begin
						res_coeff = rd_first_q.coeff;
						res_power = rd_first_q.power;
					end else if (take_second) begin
						res_coeff = rd_second_q.coeff;
						res_power = rd_second_q.power;
					end else begin
						res_power = rd_first_q.power;
						if (wide_sum[32] != wide_sum[31]) begin
							res_sat   = 1'b1;
							res_coeff = wide_sum[32] ? COEFF_MIN : COEFF_MAX;
						end else begin
							res_coeff = wide_sum[31:0];
						end
					end
					if (done) begin
						clear   = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_first_q  <= '0;
			cnt_second_q <= '0;
			idx_first_q  <= '0;
			idx_second_q <= '0;
			overflow_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			idx_first_q  <= idx_first_d;
			idx_second_q <= idx_second_d;
			if (clear) begin
				cnt_first_q  <= '0;
				cnt_second_q <= '0;
				overflow_q   <= 1'b0;
			end else begin
				if (wr_first) begin
					cnt_first_q <= cnt_first_q + 1'b1;
				end
				if (wr_second) begin
					cnt_second_q <= cnt_second_q + 1'b1;
				end
				if (drop_load) begin
					overflow_q <= 1'b1;
				end
			end
			if (slot_free) begin
				out_valid_q <= emit;
			end
		end
	end

	// The stores read the next head every cycle into a register, so the merge sees
	// it in the next cycle; while idle the read address rests on entry zero.
	always_ff @(posedge clk) begin
		if (wr_first) begin
			mem_first[cnt_first_q[AW-1:0]] <= wr_term;
		end
		if (wr_second) begin
			mem_second[cnt_second_q[AW-1:0]] <= wr_term;
		end
		rd_first_q  <= mem_first[idx_first_d[AW-1:0]];
		rd_second_q <= mem_second[idx_second_d[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (slot_free && emit) begin
			sum_coeff_q <= res_coeff;
			sum_power_q <= res_power;
			last_q      <= res_last;
			empty_res_q <= res_empty;
			saturated_q <= res_sat;
			dropped_q   <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sum_coeff = sum_coeff_q;
	assign sum_power = sum_power_q;
	assign last      = last_q;
	assign empty_res = empty_res_q;
	assign saturated = saturated_q;
	assign dropped   = dropped_q;

endmodule

`default_nettype wire

FILE: hdl/sparse_polynomial_adder_unit.sv
// Top level of the sparse polynomial adder.
// Instantiates spa_front, spa_cmd_queue and spa_back; depends on spa_pkg.
`default_nettype none

// The block holds two sparse polynomials of up to TERM_DEPTH terms each,
// loaded one term per item (action 0 for the first, 1 for the second, in
// ascending power), and a merge item (action 2) emits their sum as a run of
// result items ending with last set. Equal powers give the summed
// coefficient, saturated to 32 bits with saturated set, and a zero sum is
// still emitted. A merge of two empty polynomials gives a single item with
// empty_res and last set. Terms loaded into a full store are discarded, and
// dropped is then set on every item of the next merge run. Both stores are
// empty again after a merge. Action 3 is taken and ignored. Load items are
// taken at one per cycle while the queue has room. A merge emits one term
// per cycle unless the output stalls, up to twice TERM_DEPTH terms, as
// each store has a single read port and every emitted term advances at
// least one of them. A four-entry command queue sits between the input
// stage and the merge engine, so the input keeps taking items while a
// merge run is emitted, until the queue and the input register together
// hold five of them. The merge engine writes into a single output
// register, so it pauses for as long as a result waits there unaccepted.

module sparse_polynomial_adder_unit #(
	parameter int unsigned TERM_DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         action,
	input  wire logic signed [31:0] coeff,
	input  wire logic [15:0]        power,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      sum_coeff,
	output logic [15:0]             sum_power,
	output logic                    last,
	output logic                    empty_res,
	output logic                    saturated,
	output logic                    dropped
);
	import spa_pkg::*;

	logic push, q_full, pop, head_valid;
	cmd_t push_cmd, head_cmd;

	spa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.coeff    (coeff),
		.power    (power),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	spa_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	spa_back #(
		.TERM_DEPTH (TERM_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sum_coeff  (sum_coeff),
		.sum_power  (sum_power),
		.last       (last),
		.empty_res  (empty_res),
		.saturated  (saturated),
		.dropped    (dropped)
	);

endmodule

`default_nettype wire

FILE: hdl/spa_checker.sv
// Port-level checks of the sparse polynomial adder, and their binding.
// Depends on spa_pkg for the coefficient limits.
`default_nettype none

module spa_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic [1:0]         action,
	input wire logic signed [31:0] coeff,
	input wire logic [15:0]        power,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] sum_coeff,
	input wire logic [15:0]        sum_power,
	input wire logic               last,
	input wire logic               empty_res,
	input wire logic               saturated,
	input wire logic               dropped
);
	import spa_pkg::*;

	// A result held back by the receiver stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// The empty marker always closes its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last)
		else $error("empty marker without last");

	// The empty marker carries no term.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> sum_coeff == '0 && sum_power == '0 && !saturated)
		else $error("empty marker carries a term");

	// A clipped sum sits at one of the two limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> sum_coeff == COEFF_MAX || sum_coeff == COEFF_MIN)
		else $error("saturated result not at a limit");

endmodule

bind sparse_polynomial_adder_unit spa_checker u_checker (.*);

`default_nettype wire

FILE: tb/sparse_polynomial_adder_unit_test.sv
// Self-checking testbench of the sparse polynomial adder: it loads term pairs, merges them
// and compares every emitted sum term with its own prediction.
// Depends on spa_pkg and sparse_polynomial_adder_unit.

module sparse_polynomial_adder_unit_test;
	import spa_pkg::*;

	localparam int unsigned TERM_DEPTH     = 32;
	localparam logic [1:0]  ACT_UNUSED     = 2'd3;
	localparam int unsigned RANDOM_ITEMS   = 90;
	localparam int unsigned MIN_PAIRS      = 10;
	localparam int unsigned LONG_HOLD      = 250;
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	// One emitted term of a sum, as the block should present it.
	typedef struct {
		logic signed [31:0] coeff;
		logic [15:0]        power;
		bit                 last;
		bit                 empty;
		bit                 clipped;
		bit                 lost;
	} sum_term_t;

	// Keeps a private copy of both term stores and the drop flag, works out the terms that
	// each merge must emit and checks the terms that actually come out, oldest first.
	class poly_sum_tracker;
		term_t       first_store[TERM_DEPTH];
		term_t       second_store[TERM_DEPTH];
		int unsigned first_len;
		int unsigned second_len;
		bit          term_lost;
		sum_term_t   expected_terms[$];
		int unsigned failures;
		int unsigned seen;

		function new();
			first_len  = 0;
			second_len = 0;
			term_lost  = 1'b0;
			failures   = 0;
			seen       = 0;
		endfunction

		function int unsigned outstanding();
			return expected_terms.size();
		endfunction

		function void note_item(logic [1:0] act, logic signed [31:0] c, logic [15:0] p);
			term_t              t;
			sum_term_t          fresh;
			sum_term_t          held;
			bit                 have_held;
			int unsigned        i;
			int unsigned        j;
			logic signed [32:0] wide;
			t.coeff   = c;
			t.power   = p;
			i         = 0;
			j         = 0;
			have_held = 1'b0;
			case (act)
			ACT_LOAD_FIRST: begin
				if (first_len >= TERM_DEPTH) begin
					term_lost = 1'b1;
				end else begin
					first_store[first_len] = t;
					first_len++;
				end
			end
			ACT_LOAD_SECOND: begin
				if (second_len >= TERM_DEPTH) begin
					term_lost = 1'b1;
				end else begin
					second_store[second_len] = t;
					second_len++;
				end
			end
			ACT_MERGE: begin
				if (first_len == 0 && second_len == 0) begin
					held.coeff   = '0;
					held.power   = '0;
					held.empty   = 1'b1;
					held.clipped = 1'b0;
					held.lost    = term_lost;
				end else begin
					// Sorted merge on the head powers only; stores are not sorted first.
					while (i < first_len || j < second_len) begin
						fresh.last    = 1'b0;
						fresh.empty   = 1'b0;
						fresh.clipped = 1'b0;
						fresh.lost    = term_lost;
						if (j >= second_len || (i < first_len &&
								first_store[i].power < second_store[j].power)) begin
							fresh.coeff = first_store[i].coeff;
							fresh.power = first_store[i].power;
							i++;
						end else if (i >= first_len ||
								second_store[j].power < first_store[i].power) begin
							fresh.coeff = second_store[j].coeff;
							fresh.power = second_store[j].power;
							j++;
						end else begin
							wide = {first_store[i].coeff[31], first_store[i].coeff} +
								{second_store[j].coeff[31], second_store[j].coeff};
							if (wide[32] != wide[31]) begin
								fresh.clipped = 1'b1;
								fresh.coeff   = wide[32] ? COEFF_MIN : COEFF_MAX;
							end else begin
								fresh.coeff = wide[31:0];
							end
							fresh.power = first_store[i].power;
							i++;
							j++;
						end
						if (have_held)
							expected_terms.push_back(held);
						held      = fresh;
						have_held = 1'b1;
					end
				end
				held.last = 1'b1;
				expected_terms.push_back(held);
				first_len  = 0;
				second_len = 0;
				term_lost  = 1'b0;
			end
			default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			$display("ERROR at %0t: %s", $realtime, what);
			failures++;
		endtask

		task check_term(logic signed [31:0] c, logic [15:0] p, logic is_last,
				logic is_empty, logic is_sat, logic is_drop);
			sum_term_t want;
			seen++;
			if (expected_terms.size() == 0) begin
				report_mismatch($sformatf("term %0d arrived with nothing outstanding", seen));
			end else begin
				want = expected_terms.pop_front();
				if (c !== want.coeff)
					report_mismatch($sformatf("term %0d sum_coeff %0d, expected %0d",
						seen, c, want.coeff));
				if (p !== want.power)
					report_mismatch($sformatf("term %0d sum_power %0d, expected %0d",
						seen, p, want.power));
				if (is_last !== want.last)
					report_mismatch($sformatf("term %0d last %b, expected %b",
						seen, is_last, want.last));
				if (is_empty !== want.empty)
					report_mismatch($sformatf("term %0d empty_res %b, expected %b",
						seen, is_empty, want.empty));
				if (is_sat !== want.clipped)
					report_mismatch($sformatf("term %0d saturated %b, expected %b",
						seen, is_sat, want.clipped));
				if (is_drop !== want.lost)
					report_mismatch($sformatf("term %0d dropped %b, expected %b",
						seen, is_drop, want.lost));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         action;
	logic signed [31:0] coeff;
	logic [15:0]        power;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] sum_coeff;
	logic [15:0]        sum_power;
	logic               last;
	logic               empty_res;
	logic               saturated;
	logic               dropped;

	// calm switches random idling off on both sides; hold_now asks the receiver for one
	// long hold-off.
	bit          calm;
	bit          hold_now;
	int unsigned items_sent;

	poly_sum_tracker sums = new();

	sparse_polynomial_adder_unit #(
		.TERM_DEPTH(TERM_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.coeff    (coeff),
		.power    (power),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum_coeff(sum_coeff),
		.sum_power(sum_power),
		.last     (last),
		.empty_res(empty_res),
		.saturated(saturated),
		.dropped  (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Coefficients are mostly fully random, with a fair share near either end of the range
	// so that equal-power pairs overflow now and then, and some small values that cancel.
	function automatic logic signed [31:0] pick_coeff();
		case ($urandom_range(0, 9))
		0: return COEFF_MAX - $urandom_range(0, 3);
		1: return COEFF_MIN + $urandom_range(0, 3);
		2: return $signed($urandom_range(0, 20)) - 10;
		default: return $urandom;
		endcase
	endfunction

	// Offers one item, after a random gap unless calm, and returns at the clock edge at
	// which it is taken. Valid stays high afterwards until the next item or a pause lowers
	// it at a later falling edge. Items of the unused action do not count towards the total.
	task automatic offer_item(logic [1:0] act, logic signed [31:0] c, logic [15:0] p);
		int unsigned gap;
		gap = 0;
		while (!calm && $urandom_range(0, 99) < 22)
			gap++;
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			action   <= 2'($urandom);
			coeff    <= $urandom;
			power    <= 16'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action   <= act;
		coeff    <= c;
		power    <= p;
		do @(posedge clk); while (in_stall);
		sums.note_item(act, c, p);
		if (act != ACT_UNUSED)
			items_sent++;
	endtask

	// The sender stops offering and waits until every predicted term has come out.
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sums.outstanding() != 0) @(posedge clk);
	endtask

	// Builds two polynomials over a shared ascending run of powers, so that equal powers
	// are common, interleaves their loads at random and ends with a merge. A large pair
	// overfills one store to exercise the drop flag. A noisy pair breaks the power order
	// now and then and slips in items of the unused action.
	task automatic play_pair(int unsigned terms, bit large_pair, bit into_second, bit noisy);
		term_t       first_q[$];
		term_t       second_q[$];
		term_t       t;
		int unsigned p;
		int unsigned pick;
		int unsigned k;
		bit          to_second;
		p = $urandom_range(0, 65535 - 4 * terms - 4);
		for (k = 0; k < terms; k++) begin
			p      += $urandom_range(1, 3);
			t.power = p[15:0];
			if (large_pair)
				pick = into_second ? 1 : 0;
			else
				pick = $urandom_range(0, 2);
			if (pick != 1) begin
				t.coeff = pick_coeff();
				first_q.push_back(t);
			end
			if (pick != 0) begin
				t.coeff = pick_coeff();
				second_q.push_back(t);
			end
		end
		while (first_q.size() + second_q.size() != 0) begin
			to_second = (first_q.size() == 0) ||
				(second_q.size() != 0 && $urandom_range(0, 1) == 1);
			t = to_second ? second_q.pop_front() : first_q.pop_front();
			if (noisy && $urandom_range(0, 9) == 0)
				t.power = 16'($urandom);
			offer_item(to_second ? ACT_LOAD_SECOND : ACT_LOAD_FIRST, t.coeff, t.power);
			if (noisy && $urandom_range(0, 9) == 0)
				offer_item(ACT_UNUSED, pick_coeff(), 16'($urandom));
		end
		offer_item(ACT_MERGE, $urandom, 16'($urandom));
	endtask

	// Receiver: stalls at random unless calm, and once holds off for a long stretch so
	// that the command queue fills up behind the merge engine and the input stalls.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_now) begin
				hold_now = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 22);
			end
		end
	end

	// Every term taken from the output is checked at the edge at which it is taken.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sums.check_term(sum_coeff, sum_power, last, empty_res, saturated, dropped);
		end
	end

	// The run is abandoned when neither side has moved an item for too long.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("sparse_polynomial_adder_unit: mismatch");
		$finish;
	end

	initial begin
		int unsigned set_no;
		int unsigned stop_at;
		in_valid   = 1'b0;
		action     = ACT_LOAD_FIRST;
		coeff      = '0;
		power      = '0;
		calm       = 1'b0;
		hold_now   = 1'b0;
		items_sent = 0;
		arst_n     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A merge straight after reset finds both stores empty and gives the empty marker,
		// and an item of the unused action must leave no trace.
		offer_item(ACT_MERGE, '0, '0);
		offer_item(ACT_UNUSED, COEFF_MAX, 16'hffff);

		// Equal powers at both ends of the range: a negative overflow at power zero, a
		// positive one at power five, a zero sum at the top power, and then the first store
		// runs out while the second still holds a term.
		offer_item(ACT_LOAD_FIRST, COEFF_MIN, 16'd0);
		offer_item(ACT_LOAD_SECOND, -32'sd1, 16'd0);
		offer_item(ACT_LOAD_FIRST, COEFF_MAX, 16'd5);
		offer_item(ACT_LOAD_SECOND, 32'sd1, 16'd5);
		offer_item(ACT_LOAD_FIRST, -32'sd1, 16'hffff);
		offer_item(ACT_LOAD_SECOND, 32'sd1, 16'hffff);
		offer_item(ACT_LOAD_SECOND, 32'sd9, 16'hffff);
		offer_item(ACT_MERGE, 32'sh5a5a_a5a5, 16'h1234);

		// Only the second store holds terms.
		offer_item(ACT_LOAD_SECOND, 32'sd0, 16'd3);
		offer_item(ACT_MERGE, COEFF_MAX, 16'h8001);

		// Powers out of order in the first store: only the heads are compared.
		offer_item(ACT_LOAD_FIRST, 32'sd4, 16'd10);
		offer_item(ACT_LOAD_FIRST, 32'sd6, 16'd2);
		offer_item(ACT_LOAD_SECOND, -32'sd3, 16'd5);
		offer_item(ACT_MERGE, COEFF_MIN, 16'hffff);

		// Only the first store holds terms.
		offer_item(ACT_LOAD_FIRST, 32'sd7, 16'd1);
		offer_item(ACT_MERGE, '0, '0);

		// The sender pauses here until every term so far has come out.
		wait_for_results();

		// Random pairs. The second pair overfills the first store; the long hold-off starts
		// with the third, while the sender keeps offering; a run of pairs goes through with
		// no idling on either side; a later pair overfills the second store.
		stop_at = items_sent + RANDOM_ITEMS;
		set_no  = 0;
		while (items_sent < stop_at || set_no < MIN_PAIRS) begin
			calm = (set_no >= 4 && set_no < 8);
			if (set_no == 2)
				hold_now = 1'b1;
			if (set_no == 1)
				play_pair(33, 1'b1, 1'b0, 1'b0);
			else if (set_no == 9)
				play_pair(33, 1'b1, 1'b1, 1'b0);
			else
				play_pair($urandom_range(0, 4), 1'b0, 1'b0, (set_no % 3) == 2);
			set_no++;
		end
		calm = 1'b0;

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sums.failures == 0)
			$display("sparse_polynomial_adder_unit: match");
		else
			$display("sparse_polynomial_adder_unit: mismatch");
		$finish;
	end

endmodule
